// ===== hw/rtl/fwbi_pkg.sv =====
// Shared types, constants and helper functions of the fixed-weight basis indexer.
package fwbi_pkg;

    // Default largest chain length; the top level hands it down as MAX_SPINS.
    localparam int MAX_SPINS_DEF = 16;

    // Configuration register.
    localparam int                CFG_W         = 5;
    localparam logic [CFG_W-1:0]  NUM_SPINS_RST = 5'd16;

    // Fixed widths of the transfer fields.
    localparam int REQ_W     = 1;
    localparam int BIDX_W    = 14;
    localparam int QWORD_W   = 16;
    localparam int GLVL_W    = 3;
    localparam int GNUM_W    = 14;
    localparam int BWORD_W   = 16;
    localparam int WRANK_W   = 14;
    localparam int RCOUNT_W  = 14;

    // Width of a population count over a 32-bit word.
    localparam int POP_W = 6;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_BUILD  = 1'b0;
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 1'b1;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [BIDX_W-1:0]  basis_index;
        logic [QWORD_W-1:0] query_word;
        logic [GLVL_W-1:0]  group_level;
        logic [GNUM_W-1:0]  group_number;
    } t_in_item;

    typedef struct packed {
        logic [BWORD_W-1:0]  basis_word;
        logic [WRANK_W-1:0]  word_rank;
        logic                word_valid;
        logic [RCOUNT_W-1:0] run_count;
        logic                run_past_end;
        logic                bad_size;
        logic                build_done;
    } t_out_item;

    // Enables of the three stores.
    typedef struct packed {
        logic basis_we;
        logic rank_we;
        logic run_we;
        logic basis_re;
        logic rank_re;
        logic run_re;
    } t_mem_ctl;

    // Central binomial coefficient C(m, m/2), built up row by row of Pascal's triangle.
    function automatic int f_central_binom(input int m);
        int row [0:32];
        for (int k = 0; k <= 32; k++) begin
            row[k] = 0;
        end
        row[0] = 1;
        for (int r = 1; r <= m; r++) begin
            for (int k = r; k >= 1; k--) begin
                row[k] = row[k] + row[k-1];
            end
        end
        return row[m / 2];
    endfunction

    // Number of set bits in a word.
    function automatic logic [POP_W-1:0] f_ones(input logic [31:0] w);
        logic [POP_W-1:0] c;
        c = '0;
        for (int b = 0; b < 32; b++) begin
            c = c + POP_W'(w[b]);
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/fwbi_stores.sv =====
// Basis, rank and run-length stores: one write port and one registered read port each.
module fwbi_stores #(
    parameter int MAX_SPINS = fwbi_pkg::MAX_SPINS_DEF
) (
    input  logic                       i_clk,
    input  fwbi_pkg::t_mem_ctl         i_ctl,
    input  logic [IDX_W-1:0]           i_basis_waddr,
    input  logic [MAX_SPINS-1:0]       i_basis_wdata,
    input  logic [IDX_W-1:0]           i_basis_raddr,
    output logic [MAX_SPINS-1:0]       o_basis_rdata,
    input  logic [MAX_SPINS-1:0]       i_rank_waddr,
    input  logic [IDX_W-1:0]           i_rank_wdata,
    input  logic [MAX_SPINS-1:0]       i_rank_raddr,
    output logic [IDX_W-1:0]           o_rank_rdata,
    input  logic [RUN_AW-1:0]          i_run_waddr,
    input  logic [SIZE_W-1:0]          i_run_wdata,
    input  logic [RUN_AW-1:0]          i_run_raddr,
    output logic [SIZE_W-1:0]          o_run_rdata
);

    localparam int BINOM  = fwbi_pkg::f_central_binom(MAX_SPINS);
    localparam int IDX_W  = $clog2(BINOM);
    localparam int SIZE_W = $clog2(BINOM + 1);
    localparam int LEVELS = MAX_SPINS / 2;
    localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int RUN_AW = LVL_W + IDX_W;

    logic [MAX_SPINS-1:0] mem_basis [0:(2**IDX_W)-1];
    logic [IDX_W-1:0]     mem_rank  [0:(2**MAX_SPINS)-1];
    logic [SIZE_W-1:0]    mem_run   [0:(2**RUN_AW)-1];

    logic [MAX_SPINS-1:0] r_basis_rdata;
    logic [IDX_W-1:0]     r_rank_rdata;
    logic [SIZE_W-1:0]    r_run_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.basis_we) begin
            mem_basis[i_basis_waddr] <= i_basis_wdata;
        end
        if (i_ctl.basis_re) begin
            r_basis_rdata <= mem_basis[i_basis_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rank_we) begin
            mem_rank[i_rank_waddr] <= i_rank_wdata;
        end
        if (i_ctl.rank_re) begin
            r_rank_rdata <= mem_rank[i_rank_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.run_we) begin
            mem_run[i_run_waddr] <= i_run_wdata;
        end
        if (i_ctl.run_re) begin
            r_run_rdata <= mem_run[i_run_raddr];
        end
    end

    assign o_basis_rdata = r_basis_rdata;
    assign o_rank_rdata  = r_rank_rdata;
    assign o_run_rdata   = r_run_rdata;

endmodule

// ===== hw/rtl/fwbi_build.sv =====
// Build sequencer: walks all words, then measures the runs of every level.
module fwbi_build #(
    parameter int MAX_SPINS = fwbi_pkg::MAX_SPINS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [fwbi_pkg::CFG_W-1:0]      i_spins,
    input  logic [MAX_SPINS-1:0]            i_basis_rdata,
    output logic                            o_busy,
    output logic                            o_done,
    output fwbi_pkg::t_mem_ctl              o_ctl,
    output logic [IDX_W-1:0]                o_basis_waddr,
    output logic [MAX_SPINS-1:0]            o_basis_wdata,
    output logic [IDX_W-1:0]                o_basis_raddr,
    output logic [MAX_SPINS-1:0]            o_rank_waddr,
    output logic [IDX_W-1:0]                o_rank_wdata,
    output logic [RUN_AW-1:0]               o_run_waddr,
    output logic [SIZE_W-1:0]               o_run_wdata,
    output logic [fwbi_pkg::CFG_W-1:0]      o_built_n,
    output logic [SIZE_W-1:0]               o_size,
    output logic [LEVELS-1:0][SIZE_W-1:0]   o_run_total
);

    localparam int BINOM  = fwbi_pkg::f_central_binom(MAX_SPINS);
    localparam int IDX_W  = $clog2(BINOM);
    localparam int SIZE_W = $clog2(BINOM + 1);
    localparam int LEVELS = MAX_SPINS / 2;
    localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int RUN_AW = LVL_W + IDX_W;
    localparam int CNT_W  = MAX_SPINS + 1;
    localparam int CFG_W  = fwbi_pkg::CFG_W;
    localparam int POP_W  = fwbi_pkg::POP_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_LVL_START,
        S_LVL_RUN,
        S_LVL_END,
        S_FINISH
    } t_state;

    t_state                    r_state, n_state;
    logic [CFG_W-1:0]          r_n, n_n;
    logic [SIZE_W-1:0]         r_size, n_size;
    logic [LEVELS-1:0][SIZE_W-1:0] r_total, n_total;
    logic                      r_dv, n_dv;

    logic [CNT_W-1:0]          r_w, n_w;
    logic [LVL_W-1:0]          r_j, n_j;
    logic [SIZE_W-1:0]         r_i, n_i;
    logic                      r_dfirst, n_dfirst;
    logic [MAX_SPINS-1:0]      r_key, n_key;
    logic [SIZE_W-1:0]         r_cnt, n_cnt;
    logic [IDX_W-1:0]          r_run, n_run;

    logic [CFG_W-1:0]          half;
    logic [CNT_W-1:0]          limit;
    logic                      hit;
    logic [MAX_SPINS-1:0]      key_now;
    fwbi_pkg::t_mem_ctl        ctl;

    always_comb begin
        half    = r_n >> 1;
        limit   = CNT_W'(1) << r_n;
        hit     = fwbi_pkg::f_ones(32'(r_w[MAX_SPINS-1:0])) == POP_W'(half);
        key_now = i_basis_rdata >> (CFG_W'(r_j) + CFG_W'(1));

        n_state  = r_state;
        n_n      = r_n;
        n_size   = r_size;
        n_total  = r_total;
        n_dv     = 1'b0;
        n_w      = r_w;
        n_j      = r_j;
        n_i      = r_i;
        n_dfirst = r_dfirst;
        n_key    = r_key;
        n_cnt    = r_cnt;
        n_run    = r_run;
        ctl      = '0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_WALK;
                    n_n     = i_spins;
                    n_size  = '0;
                    n_total = '0;
                    n_w     = '0;
                end
            end
            S_WALK: begin
                ctl.basis_we = hit;
                ctl.rank_we  = hit;
                n_size       = r_size + SIZE_W'(hit);
                n_w          = r_w + CNT_W'(1);
                if (r_w + CNT_W'(1) == limit) begin
                    n_j = '0;
                    if (half == '0) begin
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_LVL_START;
                    end
                end
            end
            S_LVL_START: begin
                n_i     = '0;
                n_state = S_LVL_RUN;
            end
            S_LVL_RUN: begin
                if (r_i < r_size) begin
                    ctl.basis_re = 1'b1;
                    n_i          = r_i + SIZE_W'(1);
                    n_dv         = 1'b1;
                    n_dfirst     = (r_i == '0);
                end
                if (r_dv) begin
                    if (r_dfirst) begin
                        n_key = key_now;
                        n_cnt = SIZE_W'(1);
                        n_run = '0;
                    end else if (key_now != r_key) begin
                        ctl.run_we = 1'b1;
                        n_run      = r_run + IDX_W'(1);
                        n_key      = key_now;
                        n_cnt      = SIZE_W'(1);
                    end else begin
                        n_cnt = r_cnt + SIZE_W'(1);
                    end
                    if (r_i == r_size) begin
                        n_state = S_LVL_END;
                    end
                end
            end
            S_LVL_END: begin
                ctl.run_we   = 1'b1;
                n_total[r_j] = SIZE_W'(r_run) + SIZE_W'(1);
                if (CFG_W'(r_j) + CFG_W'(1) < half) begin
                    n_j     = r_j + LVL_W'(1);
                    n_state = S_LVL_START;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_n     <= '0;
            r_size  <= '0;
            r_total <= '0;
            r_dv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_size  <= n_size;
            r_total <= n_total;
            r_dv    <= n_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w      <= n_w;
        r_j      <= n_j;
        r_i      <= n_i;
        r_dfirst <= n_dfirst;
        r_key    <= n_key;
        r_cnt    <= n_cnt;
        r_run    <= n_run;
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_done        = (r_state == S_FINISH);
    assign o_ctl         = ctl;
    assign o_basis_waddr = IDX_W'(r_size);
    assign o_basis_wdata = r_w[MAX_SPINS-1:0];
    assign o_basis_raddr = IDX_W'(r_i);
    assign o_rank_waddr  = r_w[MAX_SPINS-1:0];
    assign o_rank_wdata  = IDX_W'(r_size);
    assign o_run_waddr   = {r_j, r_run};
    assign o_run_wdata   = r_cnt;
    assign o_built_n     = r_n;
    assign o_size        = r_size;
    assign o_run_total   = r_total;

endmodule

// ===== hw/rtl/fixed_weight_basis_indexer.sv =====
// Top level of the fixed-weight basis indexer: request channel, lookup pipeline, result register.
//
// Requests arrive on i_in_valid / i_in_data and are held off with o_in_stall; results leave on
// o_out_valid / o_out_data and the receiver holds them with i_out_stall. Every accepted request
// gives exactly one result transfer. The chain length is written through i_cfg_valid /
// i_cfg_data (o_cfg_ready is always high); the user must write it only while no request is
// outstanding, as the block itself does not enforce this. A lookup reads the basis, rank and
// run stores in one go, so lookups are taken one per cycle while the request channel is not
// stalled, and each result passes from the lookup stage into the output register. A build
// request with an odd chain length, or one above MAX_SPINS, is answered at once with bad_size
// set and leaves the stores untouched. A valid build holds off the request channel while the
// sequencer writes the stores: it walks every word, then makes n/2 level passes over the
// basis store read port, then a closing state. Its result then follows like a lookup.
// After reset the chain length is 16 and the basis is empty: no word is a member, every basis
// read gives zero and every level reads as past the end. No store is cleared after reset or
// at a build, because every read of an entry not written by the last build is masked.
// When the receiver stalls, one result waits in the output register and one more in the
// lookup stage; only then is the request channel stalled.
module fixed_weight_basis_indexer #(
    parameter int MAX_SPINS = fwbi_pkg::MAX_SPINS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  fwbi_pkg::t_in_item          i_in_data,
    output logic                        o_in_stall,
    output logic                        o_out_valid,
    output fwbi_pkg::t_out_item         o_out_data,
    input  logic                        i_out_stall,
    input  logic                        i_cfg_valid,
    input  logic [fwbi_pkg::CFG_W-1:0]  i_cfg_data,
    output logic                        o_cfg_ready
);

    localparam int BINOM    = fwbi_pkg::f_central_binom(MAX_SPINS);
    localparam int IDX_W    = $clog2(BINOM);
    localparam int SIZE_W   = $clog2(BINOM + 1);
    localparam int LEVELS   = MAX_SPINS / 2;
    localparam int LVL_W    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int RUN_AW   = LVL_W + IDX_W;
    localparam int CFG_W    = fwbi_pkg::CFG_W;
    localparam int POP_W    = fwbi_pkg::POP_W;
    localparam int BIDX_W   = fwbi_pkg::BIDX_W;
    localparam int GNUM_W   = fwbi_pkg::GNUM_W;
    localparam int GLVL_W   = fwbi_pkg::GLVL_W;
    localparam int BWORD_W  = fwbi_pkg::BWORD_W;
    localparam int WRANK_W  = fwbi_pkg::WRANK_W;
    localparam int RCOUNT_W = fwbi_pkg::RCOUNT_W;
    // Comparison widths wide enough for both sides.
    localparam int BC_W     = (SIZE_W > BIDX_W) ? SIZE_W : BIDX_W;
    localparam int GC_W     = (SIZE_W > GNUM_W) ? SIZE_W : GNUM_W;
    localparam int LC_W     = (LVL_W + 1 > GLVL_W) ? LVL_W + 1 : GLVL_W;

    // Configuration register.
    logic [CFG_W-1:0] r_spins;

    // Lookup stage, aligned with the registered store outputs.
    logic r_s1_vld, r_s1_look, r_s1_bidx_ok, r_s1_qv, r_s1_past, r_s1_bad, r_s1_done;

    // Output register.
    logic                 r_out_vld;
    fwbi_pkg::t_out_item  r_out, n_out;

    // Sequencer.
    logic                          b_busy, b_done;
    fwbi_pkg::t_mem_ctl            b_ctl;
    logic [IDX_W-1:0]              b_basis_waddr, b_basis_raddr, b_rank_wdata;
    logic [MAX_SPINS-1:0]          b_basis_wdata, b_rank_waddr;
    logic [RUN_AW-1:0]             b_run_waddr;
    logic [SIZE_W-1:0]             b_run_wdata, b_size;
    logic [CFG_W-1:0]              b_built_n;
    logic [LEVELS-1:0][SIZE_W-1:0] b_run_total;

    // Stores.
    fwbi_pkg::t_mem_ctl   m_ctl;
    logic [IDX_W-1:0]     m_basis_raddr, m_rank_rdata;
    logic [MAX_SPINS-1:0] m_basis_rdata;
    logic [SIZE_W-1:0]    m_run_rdata;

    // Request decode.
    logic              out_free, s1_adv, acc, is_look, bad_now, start, load_req, lk_re;
    logic              bidx_ok, qv_now, lvl_ok, past_now;
    logic [SIZE_W-1:0] tot;

    always_comb begin
        out_free = !r_out_vld || !i_out_stall;
        s1_adv   = r_s1_vld && out_free;
        acc      = i_in_valid && !o_in_stall;
        is_look  = (i_in_data.req_type == fwbi_pkg::REQ_LOOKUP);
        bad_now  = r_spins[0] || (r_spins > CFG_W'(MAX_SPINS));
        start    = acc && !is_look && !bad_now;
        load_req = acc && (is_look || bad_now);
        lk_re    = acc && is_look;

        // An index is only read back if the last build wrote it.
        bidx_ok  = BC_W'(i_in_data.basis_index) < BC_W'(b_size);

        // Membership: the basis holds exactly the n-bit words of weight n/2, where n is the
        // chain length of the last build; an empty basis has no members.
        qv_now   = is_look && (b_size != '0)
                   && ((i_in_data.query_word >> b_built_n) == '0)
                   && (fwbi_pkg::f_ones(32'(i_in_data.query_word)) == POP_W'(b_built_n >> 1));

        lvl_ok   = LC_W'(i_in_data.group_level) < LC_W'(LEVELS);
        tot      = lvl_ok ? b_run_total[LVL_W'(i_in_data.group_level)] : '0;
        past_now = is_look && !(GC_W'(i_in_data.group_number) < GC_W'(tot));

        m_ctl          = b_ctl;
        m_ctl.basis_re = b_ctl.basis_re || lk_re;
        m_ctl.rank_re  = lk_re;
        m_ctl.run_re   = lk_re;
        m_basis_raddr  = b_ctl.basis_re ? b_basis_raddr : IDX_W'(i_in_data.basis_index);
    end

    // Result as it leaves the lookup stage.
    always_comb begin
        n_out              = '0;
        n_out.basis_word   = (r_s1_look && r_s1_bidx_ok) ? BWORD_W'(m_basis_rdata) : '0;
        n_out.word_rank    = r_s1_qv ? WRANK_W'(m_rank_rdata) : '0;
        n_out.word_valid   = r_s1_qv;
        n_out.run_count    = (r_s1_look && !r_s1_past) ? RCOUNT_W'(m_run_rdata) : '0;
        n_out.run_past_end = r_s1_past;
        n_out.bad_size     = r_s1_bad;
        n_out.build_done   = r_s1_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spins   <= fwbi_pkg::NUM_SPINS_RST;
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_spins <= i_cfg_data;
            end
            if (load_req || b_done) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_req) begin
            r_s1_look    <= is_look;
            r_s1_bidx_ok <= bidx_ok;
            r_s1_qv      <= qv_now;
            r_s1_past    <= past_now;
            r_s1_bad     <= bad_now;
            r_s1_done    <= 1'b0;
        end else if (b_done) begin
            r_s1_look    <= 1'b0;
            r_s1_bidx_ok <= 1'b0;
            r_s1_qv      <= 1'b0;
            r_s1_past    <= 1'b0;
            r_s1_bad     <= 1'b0;
            r_s1_done    <= 1'b1;
        end
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    fwbi_build #(
        .MAX_SPINS (MAX_SPINS)
    ) u_build (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_spins       (r_spins),
        .i_basis_rdata (m_basis_rdata),
        .o_busy        (b_busy),
        .o_done        (b_done),
        .o_ctl         (b_ctl),
        .o_basis_waddr (b_basis_waddr),
        .o_basis_wdata (b_basis_wdata),
        .o_basis_raddr (b_basis_raddr),
        .o_rank_waddr  (b_rank_waddr),
        .o_rank_wdata  (b_rank_wdata),
        .o_run_waddr   (b_run_waddr),
        .o_run_wdata   (b_run_wdata),
        .o_built_n     (b_built_n),
        .o_size        (b_size),
        .o_run_total   (b_run_total)
    );

    fwbi_stores #(
        .MAX_SPINS (MAX_SPINS)
    ) u_stores (
        .i_clk         (i_clk),
        .i_ctl         (m_ctl),
        .i_basis_waddr (b_basis_waddr),
        .i_basis_wdata (b_basis_wdata),
        .i_basis_raddr (m_basis_raddr),
        .o_basis_rdata (m_basis_rdata),
        .i_rank_waddr  (b_rank_waddr),
        .i_rank_wdata  (b_rank_wdata),
        .i_rank_raddr  (MAX_SPINS'(i_in_data.query_word)),
        .o_rank_rdata  (m_rank_rdata),
        .i_run_waddr   (b_run_waddr),
        .i_run_wdata   (b_run_wdata),
        .i_run_raddr   ({LVL_W'(i_in_data.group_level), IDX_W'(i_in_data.group_number)}),
        .o_run_rdata   (m_run_rdata)
    );

    // The request channel waits while a build runs or while both result slots are full and the receiver stalls.
    assign o_in_stall  = b_busy || (r_s1_vld && !out_free);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule
